// ----- hdl/bras_pkg.sv -----
// Shared types and constants for the block range-add / range-sum engine.
package bras_pkg;

	localparam int DATA_W           = 64;
	localparam int IDX_FIELD_W      = 17;
	localparam int MAX_ELEMENTS_DEF = 65536;
	localparam int BLOCK_SIZE_DEF   = 256;

	localparam logic [IDX_FIELD_W-1:0] COUNT_RESET = 17'h10000;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_ADD   = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	typedef struct packed {
		logic        [1:0]             action;
		logic        [IDX_FIELD_W-1:0] left_index;
		logic        [IDX_FIELD_W-1:0] right_index;
		logic signed [DATA_W-1:0]      add_value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] range_sum;
		logic                     bad_range;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_SETUP,
		ST_LD_RD,
		ST_LD_WR,
		ST_BLK,
		ST_WHOLE,
		ST_WALK,
		ST_WEND,
		ST_ACC,
		ST_DONE
	} state_t;

endpackage

// ----- hdl/block_range_add_range_sum.sv -----
// Block-decomposed range add / range sum engine with a shared adder and sequencer.
//
//  channel | signals                        | direction | transfer carries
//  --------+--------------------------------+-----------+---------------------------
//  req     | req_valid, req_ready, req      | in        | load / add / query item
//  rsp     | rsp_valid, rsp_ready, rsp      | out       | query sum and bad flag
//  cfg     | cfg_valid, cfg_ready, cfg_data | in        | element count register
//
// After reset a clearing pass zeroes block sums and offsets, req_ready low. Load: idle, check,
// block index, setup, block sum read and write-back. Add/query: the same first four, then per
// block a block read, then for a whole block an offset add (add) or sum and offset adds (query),
// for a partial block an element walk at one element access a cycle, a walk end and an accumulate.
// A query then posts its result; an ignored item ends at the check, a bad query posts from there.
// One item at a time; the result sits in an output register, so the next item is taken while
// it waits, and a query only stalls at its end if the previous result is still untaken.
module block_range_add_range_sum #(
	parameter int MAX_ELEMENTS = bras_pkg::MAX_ELEMENTS_DEF,
	parameter int BLOCK_SIZE   = bras_pkg::BLOCK_SIZE_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  bras_pkg::req_t                       req,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output bras_pkg::rsp_t                       rsp,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bras_pkg::IDX_FIELD_W-1:0]     cfg_data
);

	localparam int DW          = bras_pkg::DATA_W;
	localparam int FW          = bras_pkg::IDX_FIELD_W;
	localparam int IDX_W       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int N_W         = $clog2(MAX_ELEMENTS + 1);
	localparam int IW          = ((N_W > FW) ? N_W : FW) + 1;
	localparam int BLOCK_COUNT = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam int BLK_W       = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
	localparam int CNT_W       = $clog2(BLOCK_SIZE + 1);
	// block index of (left - 1) by reciprocal multiply; exact for every value below 2^IDX_W
	localparam int RCP_SH      = IDX_W + $clog2(BLOCK_SIZE);
	localparam int RCP_PW      = 2 * IDX_W + 2;
	localparam logic [RCP_PW-1:0] RCP_M =
		RCP_PW'(((64'd1 << RCP_SH) + 64'(BLOCK_SIZE - 1)) / 64'(BLOCK_SIZE));

	// storage
	logic [DW-1:0] elem_mem [MAX_ELEMENTS];
	logic [DW-1:0] bsum_mem [BLOCK_COUNT];
	logic [DW-1:0] boff_mem [BLOCK_COUNT];

	bras_pkg::state_t state_q, state_d;

	logic [FW-1:0]    count_q;
	logic [BLK_W-1:0] clr_q;
	logic             pend_q;
	logic             rsp_valid_q;
	bras_pkg::rsp_t   rsp_q;

	logic [1:0]       act_q;
	logic [IW-1:0]    l_q, r_q, n_q, lo_q, j_q, z_q;
	logic [DW-1:0]    v_q, acc_q, prod_q;
	logic             bad_q;
	logic [BLK_W-1:0] dq_q;
	logic [IDX_W-1:0] jp_q;
	logic [BLK_W-1:0] b_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    elem_rd_q, bsum_rd_q, boff_rd_q;

	// combinational
	logic              is_add, is_query;
	logic [IW-1:0]     live_n, l_m1, j_m1, hi_w, hi, a_sel, z_sel, next_lo, span;
	logic              in_lo, load_ok, rng_ok, partial, more, clr_last, out_space, adv;
	logic [RCP_PW-1:0] rcp_prod;
	logic [DW-1:0]     op_a, op_b, add_sum, mop;
	logic              acc_en;
	logic              elem_we, elem_re, bsum_we, bsum_re, boff_we, boff_re;
	logic [IDX_W-1:0]  elem_wa;
	logic [BLK_W-1:0]  blk_wa;
	logic [DW-1:0]     elem_wd, bsum_wd, boff_wd;

	assign is_add   = (act_q == bras_pkg::ACT_ADD);
	assign is_query = (act_q == bras_pkg::ACT_QUERY);

	assign live_n = (IW'(count_q) > IW'(MAX_ELEMENTS)) ? IW'(MAX_ELEMENTS) : IW'(count_q);
	assign l_m1   = l_q - IW'(1);
	assign j_m1   = j_q - IW'(1);
	assign in_lo  = (l_q != '0);
	assign load_ok = in_lo && (l_q <= n_q);
	assign rng_ok  = in_lo && (r_q <= n_q) && (l_q <= r_q);

	// current block bounds, clipped to the range and to the live count
	assign hi_w    = lo_q + IW'(BLOCK_SIZE - 1);
	assign hi      = (hi_w < n_q) ? hi_w : n_q;
	assign partial = (l_q > lo_q) || (r_q < hi);
	assign a_sel   = (l_q > lo_q) ? l_q : lo_q;
	assign z_sel   = (r_q < hi) ? r_q : hi;
	assign span    = z_sel - a_sel + IW'(1);
	assign next_lo = lo_q + IW'(BLOCK_SIZE);
	assign more    = (next_lo <= r_q);

	assign clr_last  = (clr_q == BLK_W'(BLOCK_COUNT - 1));
	assign out_space = !rsp_valid_q || rsp_ready;

	assign rcp_prod = RCP_PW'(l_m1[IDX_W-1:0]) * RCP_M;

	// operand of the offset multiply: pending offset for a query, add value for an add
	assign mop = is_query ? boff_rd_q : v_q;

	assign adv = (state_q == bras_pkg::ST_ACC) || ((state_q == bras_pkg::ST_WHOLE) && is_add);

	// shared adder
	assign add_sum = op_a + op_b;

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		op_a      = acc_q;
		op_b      = prod_q;
		acc_en    = 1'b0;
		elem_we   = 1'b0;
		elem_re   = 1'b0;
		bsum_we   = 1'b0;
		bsum_re   = 1'b0;
		boff_we   = 1'b0;
		boff_re   = 1'b0;
		elem_wa   = jp_q;
		elem_wd   = add_sum;
		blk_wa    = b_q;
		bsum_wd   = add_sum;
		boff_wd   = add_sum;

		// element from the walk pipeline, in the cycle after its read
		if (pend_q) begin
			op_a = elem_rd_q;
			op_b = is_query ? acc_q : v_q;
			if (is_query) begin
				acc_en = 1'b1;
			end else begin
				elem_we = 1'b1;
			end
		end

		unique case (state_q)
			bras_pkg::ST_CLEAR: begin
				bsum_we = 1'b1;
				boff_we = 1'b1;
				blk_wa  = clr_q;
				bsum_wd = '0;
				boff_wd = '0;
				if (clr_last) begin
					state_d = bras_pkg::ST_IDLE;
				end
			end
			bras_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = bras_pkg::ST_CHECK;
				end
			end
			bras_pkg::ST_CHECK: begin
				priority if (act_q == bras_pkg::ACT_LOAD) begin
					state_d = load_ok ? bras_pkg::ST_DIV : bras_pkg::ST_IDLE;
				end else if (is_add) begin
					state_d = rng_ok ? bras_pkg::ST_DIV : bras_pkg::ST_IDLE;
				end else if (is_query) begin
					state_d = rng_ok ? bras_pkg::ST_DIV : bras_pkg::ST_DONE;
				end else begin
					state_d = bras_pkg::ST_IDLE;
				end
			end
			bras_pkg::ST_DIV: begin
				state_d = bras_pkg::ST_SETUP;
			end
			bras_pkg::ST_SETUP: begin
				state_d = (act_q == bras_pkg::ACT_LOAD) ? bras_pkg::ST_LD_RD : bras_pkg::ST_BLK;
			end
			bras_pkg::ST_LD_RD: begin
				bsum_re = 1'b1;
				elem_we = 1'b1;
				elem_wa = l_m1[IDX_W-1:0];
				elem_wd = v_q;
				state_d = bras_pkg::ST_LD_WR;
			end
			bras_pkg::ST_LD_WR: begin
				op_a    = bsum_rd_q;
				op_b    = v_q;
				bsum_we = 1'b1;
				state_d = bras_pkg::ST_IDLE;
			end
			bras_pkg::ST_BLK: begin
				bsum_re = 1'b1;
				boff_re = 1'b1;
				state_d = partial ? bras_pkg::ST_WALK : bras_pkg::ST_WHOLE;
			end
			bras_pkg::ST_WHOLE: begin
				if (is_query) begin
					op_a    = acc_q;
					op_b    = bsum_rd_q;
					acc_en  = 1'b1;
					state_d = bras_pkg::ST_ACC;
				end else begin
					op_a    = boff_rd_q;
					op_b    = v_q;
					boff_we = 1'b1;
					state_d = more ? bras_pkg::ST_BLK : bras_pkg::ST_IDLE;
				end
			end
			bras_pkg::ST_WALK: begin
				elem_re = 1'b1;
				if (j_q == z_q) begin
					state_d = bras_pkg::ST_WEND;
				end
			end
			bras_pkg::ST_WEND: begin
				state_d = bras_pkg::ST_ACC;
			end
			bras_pkg::ST_ACC: begin
				if (is_query) begin
					op_a   = acc_q;
					op_b   = prod_q;
					acc_en = 1'b1;
				end else begin
					op_a    = bsum_rd_q;
					op_b    = prod_q;
					bsum_we = 1'b1;
				end
				if (more) begin
					state_d = bras_pkg::ST_BLK;
				end else begin
					state_d = is_query ? bras_pkg::ST_DONE : bras_pkg::ST_IDLE;
				end
			end
			bras_pkg::ST_DONE: begin
				if (out_space) begin
					state_d = bras_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bras_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bras_pkg::ST_CLEAR;
			count_q     <= bras_pkg::COUNT_RESET;
			clr_q       <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= (state_q == bras_pkg::ST_WALK);
			if (cfg_valid) begin
				count_q <= cfg_data;
			end
			if (state_q == bras_pkg::ST_CLEAR) begin
				clr_q <= clr_q + BLK_W'(1);
			end
			if ((state_q == bras_pkg::ST_DONE) && out_space) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			act_q <= req.action;
			l_q   <= IW'(req.left_index);
			r_q   <= IW'(req.right_index);
			v_q   <= req.add_value;
			n_q   <= live_n;
		end
		if (state_q == bras_pkg::ST_CHECK) begin
			acc_q <= '0;
			bad_q <= !rng_ok;
		end else if (acc_en) begin
			acc_q <= add_sum;
		end
		if (state_q == bras_pkg::ST_DIV) begin
			dq_q <= BLK_W'(rcp_prod >> RCP_SH);
		end
		if (state_q == bras_pkg::ST_SETUP) begin
			b_q  <= dq_q;
			lo_q <= IW'(dq_q) * IW'(BLOCK_SIZE) + IW'(1);
		end else if (adv) begin
			b_q  <= b_q + BLK_W'(1);
			lo_q <= next_lo;
		end
		if (state_q == bras_pkg::ST_BLK) begin
			j_q   <= a_sel;
			z_q   <= z_sel;
			cnt_q <= span[CNT_W-1:0];
		end else if (state_q == bras_pkg::ST_WALK) begin
			j_q  <= j_q + IW'(1);
			jp_q <= j_m1[IDX_W-1:0];
		end
		prod_q <= mop * DW'(cnt_q);
		if ((state_q == bras_pkg::ST_DONE) && out_space) begin
			rsp_q.range_sum <= acc_q;
			rsp_q.bad_range <= bad_q;
		end
	end

	// element store
	always_ff @(posedge clk) begin
		if (elem_we) begin
			elem_mem[elem_wa] <= elem_wd;
		end
		if (elem_re) begin
			elem_rd_q <= elem_mem[j_m1[IDX_W-1:0]];
		end
	end

	// block sums
	always_ff @(posedge clk) begin
		if (bsum_we) begin
			bsum_mem[blk_wa] <= bsum_wd;
		end
		if (bsum_re) begin
			bsum_rd_q <= bsum_mem[b_q];
		end
	end

	// block offsets
	always_ff @(posedge clk) begin
		if (boff_we) begin
			boff_mem[blk_wa] <= boff_wd;
		end
		if (boff_re) begin
			boff_rd_q <= boff_mem[b_q];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	// a pending element only ever follows a walk read
	a_pend_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> ($past(state_q) == bras_pkg::ST_WALK))
		else $error("pending element without a walk read");

	a_walk_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bras_pkg::ST_WALK) |-> (j_q <= z_q))
		else $error("walk index ran past block end");

	a_block_overlaps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bras_pkg::ST_BLK) |-> (lo_q <= r_q))
		else $error("block visited beyond range end");

	a_done_is_query: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bras_pkg::ST_DONE) |-> (act_q == bras_pkg::ACT_QUERY))
		else $error("result produced for a non-query item");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == bras_pkg::ST_DONE))
		else $error("result raised outside completion");

endmodule

// ----- test/range_sum_checker.sv -----
// Checker: mirrors the block sums, offsets and elements and compares every query result.
module range_sum_checker
	import bras_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	input  logic                   req_ready,
	input  req_t                   req,
	input  logic                   rsp_valid,
	input  logic                   rsp_ready,
	input  rsp_t                   rsp,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [IDX_FIELD_W-1:0] cfg_data,
	output int unsigned            mismatch_cnt,
	output int unsigned            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BS   = BLOCK_SIZE_DEF;
	localparam int MAXN = MAX_ELEMENTS_DEF;
	localparam int NBLK = (MAXN + BS - 1) / BS;

	logic [DATA_W-1:0]      elem_val  [MAXN];
	logic [DATA_W-1:0]      blk_total [NBLK];
	logic [DATA_W-1:0]      blk_pend  [NBLK];
	logic [IDX_FIELD_W-1:0] count_reg;
	rsp_t                   expected_sums [$];

	int unsigned       n, l, r, result_no;
	bit                ok;
	logic [DATA_W-1:0] total;
	rsp_t              want;

	task automatic report_mismatch(input string what);
		mismatch_cnt++;
		$display("%0t ns mismatch: %s", $realtime, what);
	endtask

	// Walks the blocks of [lo_idx, hi_idx]: partial blocks element by element, whole blocks
	// through their offset. Adds v when do_add is set, otherwise returns the range total.
	task automatic sweep_blocks(input bit do_add, input int unsigned lo_idx, hi_idx, cnt,
			input logic [DATA_W-1:0] v, output logic [DATA_W-1:0] acc);
		int unsigned lo, hi, a, z;
		acc = '0;
		for (int unsigned b = (lo_idx - 1) / BS; b <= (hi_idx - 1) / BS && b < NBLK; b++) begin
			lo = b * BS + 1;
			hi = ((b + 1) * BS < cnt) ? (b + 1) * BS : cnt;
			if (lo_idx > lo || hi_idx < hi) begin
				a = (lo_idx > lo) ? lo_idx : lo;
				z = (hi_idx < hi) ? hi_idx : hi;
				if (do_add)
					blk_total[b] += DATA_W'(z - a + 1) * v;
				else
					acc += DATA_W'(z - a + 1) * blk_pend[b];
				for (int unsigned j = a; j <= z; j++) begin
					if (do_add)
						elem_val[j - 1] += v;
					else
						acc += elem_val[j - 1];
				end
			end else if (do_add) begin
				blk_pend[b] += v;
			end else begin
				acc += blk_total[b] + DATA_W'(hi - lo + 1) * blk_pend[b];
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_reg = COUNT_RESET;
			for (int b = 0; b < NBLK; b++) begin
				blk_total[b] = '0;
				blk_pend[b]  = '0;
			end
			expected_sums.delete();
			mismatch_cnt = 0;
			result_no    = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				count_reg = cfg_data;
			if (req_valid && req_ready) begin
				n  = (count_reg > MAXN) ? MAXN : count_reg;
				l  = req.left_index;
				r  = req.right_index;
				ok = l >= 1 && r <= n && l <= r;
				case (req.action)
					ACT_LOAD: begin
						// a reload adds again; the old value stays in the block sum
						if (l >= 1 && l <= n) begin
							elem_val[l - 1] = req.add_value;
							blk_total[(l - 1) / BS] += req.add_value;
						end
					end
					ACT_ADD: begin
						if (ok)
							sweep_blocks(1'b1, l, r, n, req.add_value, total);
					end
					ACT_QUERY: begin
						total = '0;
						if (ok)
							sweep_blocks(1'b0, l, r, n, '0, total);
						want.range_sum = total;
						want.bad_range = !ok;
						expected_sums.push_back(want);
					end
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				result_no++;
				if (expected_sums.size() == 0) begin
					report_mismatch($sformatf("result %0d with no query outstanding (sum %h bad %b)",
						result_no, rsp.range_sum, rsp.bad_range));
				end else begin
					want = expected_sums.pop_front();
					if (rsp.range_sum !== want.range_sum)
						report_mismatch($sformatf("result %0d range_sum %h, expected %h",
							result_no, rsp.range_sum, want.range_sum));
					if (rsp.bad_range !== want.bad_range)
						report_mismatch($sformatf("result %0d bad_range %b, expected %b",
							result_no, rsp.bad_range, want.bad_range));
				end
			end
		end
		pending = expected_sums.size();
	end

endmodule

// ----- test/tb.sv -----
// Testbench top: clock, reset, load/add/query stimulus, count register phases and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bras_pkg::*;

	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam int MAXN         = MAX_ELEMENTS_DEF;
	localparam int BS           = BLOCK_SIZE_DEF;
	localparam int IDX_TOP      = 2 ** IDX_FIELD_W - 1;
	localparam int DRAIN_CYCLES = 1500;
	localparam int STALL_LIMIT  = 20000;
	localparam int PHASE_ITEMS  = 85;
	localparam logic [DATA_W-1:0] MIN64 = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] MAX64 = {1'b0, {(DATA_W-1){1'b1}}};

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   req_valid = 1'b0;
	logic                   req_ready;
	req_t                   req       = '0;
	logic                   rsp_valid;
	logic                   rsp_ready = 1'b0;
	rsp_t                   rsp;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [IDX_FIELD_W-1:0] cfg_data  = '0;

	int unsigned mismatch_cnt, pending;

	logic [IDX_FIELD_W-1:0] phase_counts [9] = '{17'd300, 17'd0, 17'd131071, 17'd1, 17'd700,
		17'd65535, 17'd513, 17'd65536, 17'd260};

	bit          loaded [MAXN];
	int unsigned live_n       = MAXN;
	int unsigned hot_lo       = 1;
	int unsigned hot_hi       = MAXN;
	int unsigned items_sent   = 0;
	int unsigned snd_idle_pct = 17;
	int unsigned rcv_idle_pct = 63;
	int unsigned stall_cycles = 0;

	block_range_add_range_sum i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	range_sum_checker i_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp          (rsp),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.mismatch_cnt (mismatch_cnt),
		.pending      (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);

	// any transfer on any channel counts as progress
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("** block_range_add_range_sum: FAILED **");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic req_t pack_item(input logic [1:0] act, input int unsigned l, r,
			input logic [DATA_W-1:0] v);
		req_t it;
		it.action      = act;
		it.left_index  = IDX_FIELD_W'(l);
		it.right_index = IDX_FIELD_W'(r);
		it.add_value   = v;
		return it;
	endfunction

	function automatic logic [DATA_W-1:0] rand_value();
		case ($urandom_range(9))
			0: return MIN64;
			1: return MAX64;
			2: return '1;
			3: return DATA_W'($urandom_range(15));
			4: return -DATA_W'($urandom_range(15));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Called in the step right after a rising edge; returns in the step of the transfer.
	task automatic send_item(input req_t it);
		int unsigned l;
		l = it.left_index;
		while ($urandom_range(99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		do @(posedge clk); while (!req_ready);
		if (it.action == ACT_LOAD && l >= 1 && l <= live_n)
			loaded[l - 1] = 1'b1;
		items_sent++;
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Picks a range for an add or a query. Good ranges never read an unloaded element:
	// a few holes in the partial blocks get loaded first, many holes widen to whole blocks.
	task automatic make_range(output int unsigned l, output int unsigned r);
		int unsigned lo, hi, b, tmp;
		int unsigned holes [$];
		if (live_n == 0 || $urandom_range(9) == 0) begin
			case ($urandom_range(3))
				0: begin
					l = 0;
					r = $urandom_range(IDX_TOP);
				end
				1: begin
					r = $urandom_range(IDX_TOP, live_n + 1);
					l = $urandom_range(r, 1);
				end
				2: begin
					r = $urandom_range(IDX_TOP - 1);
					l = $urandom_range(IDX_TOP, r + 1);
				end
				default: begin
					l = $urandom_range(IDX_TOP);
					r = $urandom_range(IDX_TOP);
					if (l >= 1 && l <= r && r <= live_n)
						l = 0;
				end
			endcase
			return;
		end
		case ($urandom_range(9))
			0, 1, 2: begin
				l = $urandom_range(hot_hi, hot_lo);
				r = l + $urandom_range(11);
				if (r > live_n)
					r = live_n;
			end
			3, 4: begin
				// straddle a block edge
				b = $urandom_range((hot_hi - 1) / BS, (hot_lo - 1) / BS);
				l = (b * BS > 6) ? b * BS - $urandom_range(6) : 1;
				r = b * BS + 1 + $urandom_range(6);
				if (r > live_n)
					r = live_n;
			end
			5: begin
				l = 1;
				r = live_n;
			end
			6: begin
				b = $urandom_range((live_n - 1) / BS);
				l = b * BS + 1;
				r = (b + 1 + $urandom_range(3)) * BS;
				if (r > live_n)
					r = live_n;
			end
			default: begin
				l = $urandom_range(live_n, 1);
				r = $urandom_range(live_n, 1);
				if (l > r) begin
					tmp = l;
					l   = r;
					r   = tmp;
				end
			end
		endcase
		for (b = (l - 1) / BS; b <= (r - 1) / BS; b++) begin
			lo = b * BS + 1;
			hi = ((b + 1) * BS < live_n) ? (b + 1) * BS : live_n;
			if (l > lo || r < hi) begin
				for (int unsigned j = (l > lo ? l : lo); j <= (r < hi ? r : hi); j++)
					if (!loaded[j - 1])
						holes.push_back(j);
			end
		end
		if (holes.size() > 16) begin
			l = ((l - 1) / BS) * BS + 1;
			r = ((r - 1) / BS + 1) * BS;
			if (r > live_n)
				r = live_n;
		end else begin
			foreach (holes[k])
				send_item(pack_item(ACT_LOAD, holes[k], $urandom_range(IDX_TOP), rand_value()));
		end
	endtask

	initial begin
		int unsigned l, r, pick, phase_start;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, count at its reset value
		send_item(pack_item(ACT_LOAD, 1, 1, MAX64));
		send_item(pack_item(ACT_LOAD, 2, 0, MIN64));
		send_item(pack_item(ACT_LOAD, 256, 0, '1));
		send_item(pack_item(ACT_LOAD, 257, 0, 64'd5));
		send_item(pack_item(ACT_LOAD, 65536, IDX_TOP, MIN64));
		send_item(pack_item(ACT_LOAD, 65281, 0, 64'd3));
		send_item(pack_item(ACT_LOAD, 0, 0, 64'd9));
		send_item(pack_item(ACT_LOAD, IDX_TOP, IDX_TOP, 64'd1));
		send_item(pack_item(ACT_QUERY, 1, 65536, '0));
		send_item(pack_item(ACT_QUERY, 1, 1, '0));
		send_item(pack_item(ACT_QUERY, 256, 257, '0));
		send_item(pack_item(ACT_ADD, 1, 65536, MAX64));
		send_item(pack_item(ACT_ADD, 2, 2, 64'd11));
		send_item(pack_item(ACT_ADD, 256, 257, MIN64));
		send_item(pack_item(ACT_QUERY, 1, 2, '1));
		send_item(pack_item(ACT_QUERY, 65281, 65536, '0));
		send_item(pack_item(ACT_QUERY, 65536, 65536, '0));
		send_item(pack_item(ACT_ADD, 0, 3, 64'd1));
		send_item(pack_item(ACT_QUERY, 0, 3, '0));
		send_item(pack_item(ACT_QUERY, 5, 4, '0));
		send_item(pack_item(ACT_QUERY, 1, 65537, '0));
		send_item(pack_item(ACT_QUERY, IDX_TOP, IDX_TOP, '0));
		send_item(pack_item(ACT_SPARE, 3, 9, '1));
		send_item(pack_item(ACT_LOAD, 1, 0, 64'd7));
		send_item(pack_item(ACT_QUERY, 1, 256, '0));

		for (int p = 0; p < 9; p++) begin
			if (p == 3) begin
				snd_idle_pct = 63;
				rcv_idle_pct = 17;
			end else if (p == 6) begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			// count changes only with the engine idle
			req_valid <= 1'b0;
			wait_idle();
			cfg_valid <= 1'b1;
			cfg_data  <= phase_counts[p];
			do @(posedge clk); while (!cfg_ready);
			cfg_valid <= 1'b0;
			live_n = (phase_counts[p] > MAXN) ? MAXN : phase_counts[p];
			hot_lo = (live_n > 600) ? $urandom_range(live_n - 599, 1) : 1;
			hot_hi = (live_n > 600) ? hot_lo + 599 : live_n;

			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 4) begin
					send_item(pack_item(ACT_SPARE, $urandom_range(IDX_TOP), $urandom_range(IDX_TOP),
						rand_value()));
				end else if (pick < 26) begin
					if (live_n == 0 || $urandom_range(9) == 0)
						l = (live_n == 0 || $urandom_range(1)) ?
							$urandom_range(IDX_TOP, live_n + 1) : 0;
					else if ($urandom_range(9) < 7)
						l = $urandom_range(hot_hi, hot_lo);
					else
						l = $urandom_range(live_n, 1);
					send_item(pack_item(ACT_LOAD, l, $urandom_range(IDX_TOP), rand_value()));
				end else if (pick < 60) begin
					make_range(l, r);
					send_item(pack_item(ACT_ADD, l, r, rand_value()));
				end else begin
					make_range(l, r);
					send_item(pack_item(ACT_QUERY, l, r, rand_value()));
				end
			end
		end

		req_valid <= 1'b0;
		wait_idle();
		@(negedge clk);
		if (mismatch_cnt == 0)
			$display("** block_range_add_range_sum: PASSED **");
		else
			$display("** block_range_add_range_sum: FAILED **");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/bras_pkg.sv
hdl/block_range_add_range_sum.sv
test/range_sum_checker.sv
test/tb.sv
